[rtl/core/cosine_similarity_core_macros.svh]
// assertion macros shared by the checker file of the cosine similarity core
`ifndef COSINE_SIMILARITY_CORE_MACROS_SVH
`define COSINE_SIMILARITY_CORE_MACROS_SVH

// clocked assertion that is switched off while reset is high
`define CSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked around reset
`define CSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/cossim_pkg.sv]
// ----------------------------------------------------------------------------
// cossim_pkg
// Widths, word types and constants shared by the cosine similarity core.
// ----------------------------------------------------------------------------
`default_nettype none

package cossim_pkg;

   // element and product widths
   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int SQ_W       = 2 * ELEM_W - 1;

   // accumulator widths
   localparam int DOT_W      = 41;
   localparam int NORM_W     = 40;
   localparam int MAG_W      = DOT_W;

   // result word
   localparam int OUT_W      = 16;
   localparam int Q_W        = 16;
   localparam int TOP_BIT    = Q_W - 1;
   localparam int FRAC_SHIFT = 2 * (OUT_W - 1);

   // pair queue between front and back, depth is a power of two
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   // sequential multiplier built from four partial products
   localparam int PART_W     = (MAG_W + 1) / 2;
   localparam int PP_W       = 2 * PART_W;
   localparam int ACC_W      = 2 * MAG_W;
   localparam int P_W        = 2 * NORM_W;
   localparam int MUL_STEPS  = 4;

   // square root search remainder width
   localparam int REM_W      = ACC_W + FRAC_SHIFT + 1;
   localparam int STEP_W     = 4;

   // input word
   typedef struct packed {
      logic signed [ELEM_W-1:0] elem_a;
      logic signed [ELEM_W-1:0] elem_b;
      logic                     last_pair;
   } cossim_req_type;

   // result word
   typedef struct packed {
      logic signed [OUT_W-1:0] similarity;
      logic                    degenerate;
   } cossim_rsp_type;

   // queued products of one pair
   typedef struct packed {
      logic signed [PROD_W-1:0] prod_ab;
      logic [SQ_W-1:0]          sq_a;
      logic [SQ_W-1:0]          sq_b;
      logic                     last;
   } cossim_entry_type;

   // totals handed from the accumulator to the finishing unit
   typedef struct packed {
      logic                    start;
      logic signed [DOT_W-1:0] dot;
      logic [NORM_W-1:0]       norm_a;
      logic [NORM_W-1:0]       norm_b;
   } cossim_job_type;

   // queue status toward the front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } cossim_fifo_status_type;

endpackage

`default_nettype wire

[rtl/core/cosine_similarity_core.sv]
// ----------------------------------------------------------------------------
// cosine_similarity_core
// Streaming cosine similarity of two Q1.15 vectors given as element pairs.
// ----------------------------------------------------------------------------
// One element pair is taken per cycle while the four-word queue has room and
// summed at one pair per cycle, so long vectors stream at full rate. The pair
// marked last closes the vectors: its totals go through the shared 21x21
// multiplier (norm product, then square of the dot) and the square root
// search over the 16 quotient bits, with an add and a compare state per bit.
// Pairs of the next vectors keep flowing meanwhile; only their closing pair
// waits until the previous result word has been taken. Zero norm gives
// similarity 0 with degenerate set; a full positive match saturates to 32767.
`default_nettype none

module cosine_similarity_core import cossim_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire cossim_req_type  req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output cossim_rsp_type       rsp_data
);

   cossim_fifo_status_type fifo_status;
   cossim_entry_type       push_entry;
   cossim_entry_type       head_entry;
   cossim_job_type         job;
   logic                   push;
   logic                   pop;
   logic                   finish_busy;

   // front: accept pairs and form products
   cossim_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .fifo_status (fifo_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   // queue between front and back
   cossim_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (fifo_status)
   );

   // back: running sums
   cossim_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .head_entry  (head_entry),
      .fifo_status (fifo_status),
      .finish_busy (finish_busy),
      .pop         (pop),
      .job         (job)
   );

   // back: quotient and result word
   cossim_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .busy      (finish_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/core/cossim_front.sv]
// ----------------------------------------------------------------------------
// cossim_front
// Accepts element pairs and forms the three products of each pair.
// ----------------------------------------------------------------------------
`default_nettype none

module cossim_front import cossim_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire cossim_req_type         req_data,
   input  wire cossim_fifo_status_type fifo_status,
   output logic                        push,
   output cossim_entry_type            push_entry
);

   logic signed [ELEM_W-1:0] a;
   logic signed [ELEM_W-1:0] b;
   logic signed [PROD_W-1:0] ab;
   logic signed [PROD_W-1:0] aa;
   logic signed [PROD_W-1:0] bb;
   logic                     unused_reset;

   // take a word whenever the queue has room
   assign req_ready = !fifo_status.full;
   assign push      = req_valid && req_ready;

   // products of the pair, registered in the queue entry
   assign a  = req_data.elem_a;
   assign b  = req_data.elem_b;
   assign ab = a * b;
   assign aa = a * a;
   assign bb = b * b;

   always_comb begin
      push_entry.prod_ab = ab;
      push_entry.sq_a    = aa[SQ_W-1:0];
      push_entry.sq_b    = bb[SQ_W-1:0];
      push_entry.last    = req_data.last_pair;
   end

   // front holds no state of its own
   assign unused_reset = reset ^ clock;

endmodule

`default_nettype wire

[rtl/core/cossim_fifo.sv]
// ----------------------------------------------------------------------------
// cossim_fifo
// Short queue of pair products between the front and the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module cossim_fifo import cossim_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire cossim_entry_type       push_entry,
   input  wire logic                   pop,
   output cossim_entry_type            head_entry,
   output cossim_fifo_status_type      status
);

   cossim_entry_type     mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff;
   logic [FIFO_AW-1:0]   wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff;
   logic [FIFO_AW-1:0]   rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff;
   logic [FIFO_CW-1:0]   count_in;

   // status and head word
   assign status.full      = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign head_entry       = mem_ff[rd_ptr_ff];

   // pointer and fill count update, pointers wrap at the depth
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/core/cossim_accum.sv]
// ----------------------------------------------------------------------------
// cossim_accum
// Sums the queued products with saturation and hands the totals of each
// vector pair to the finishing unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cossim_accum import cossim_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cossim_entry_type       head_entry,
   input  wire cossim_fifo_status_type fifo_status,
   input  wire logic                   finish_busy,
   output logic                        pop,
   output cossim_job_type              job
);

   logic signed [DOT_W-1:0] dot_ff;
   logic signed [DOT_W-1:0] dot_in;
   logic [NORM_W-1:0]       norm_a_ff;
   logic [NORM_W-1:0]       norm_a_in;
   logic [NORM_W-1:0]       norm_b_ff;
   logic [NORM_W-1:0]       norm_b_in;
   logic                    start_ff;
   logic                    start_in;
   cossim_job_type          job_ff;

   logic signed [DOT_W:0]   dot_sum;
   logic [NORM_W:0]         norm_a_sum;
   logic [NORM_W:0]         norm_b_sum;
   logic signed [DOT_W-1:0] dot_sat;
   logic [NORM_W-1:0]       norm_a_sat;
   logic [NORM_W-1:0]       norm_b_sat;
   logic                    finish_free;

   // a closing pair waits until the finishing unit is free
   assign finish_free = !finish_busy && !start_ff;
   assign pop         = fifo_status.not_empty && (!head_entry.last || finish_free);

   // saturating sums
   always_comb begin
      dot_sum    = (DOT_W+1)'(dot_ff) + (DOT_W+1)'(head_entry.prod_ab);
      norm_a_sum = {1'b0, norm_a_ff} + (NORM_W+1)'(head_entry.sq_a);
      norm_b_sum = {1'b0, norm_b_ff} + (NORM_W+1)'(head_entry.sq_b);

      if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
         dot_sat = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
      end else begin
         dot_sat = dot_sum[DOT_W-1:0];
      end
      norm_a_sat = norm_a_sum[NORM_W] ? {NORM_W{1'b1}} : norm_a_sum[NORM_W-1:0];
      norm_b_sat = norm_b_sum[NORM_W] ? {NORM_W{1'b1}} : norm_b_sum[NORM_W-1:0];
   end

   // accumulate, or clear after the closing pair
   always_comb begin
      dot_in    = dot_ff;
      norm_a_in = norm_a_ff;
      norm_b_in = norm_b_ff;
      start_in  = 1'b0;
      if (pop) begin
         if (head_entry.last) begin
            dot_in    = '0;
            norm_a_in = '0;
            norm_b_in = '0;
            start_in  = 1'b1;
         end else begin
            dot_in    = dot_sat;
            norm_a_in = norm_a_sat;
            norm_b_in = norm_b_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff    <= '0;
         norm_a_ff <= '0;
         norm_b_ff <= '0;
         start_ff  <= 1'b0;
      end else begin
         dot_ff    <= dot_in;
         norm_a_ff <= norm_a_in;
         norm_b_ff <= norm_b_in;
         start_ff  <= start_in;
      end
   end

   // totals of the closing pair, start bit is carried separately in start_ff
   always_ff @(posedge clock) begin
      if (start_in) begin
         job_ff.start  <= 1'b0;
         job_ff.dot    <= dot_sat;
         job_ff.norm_a <= norm_a_sat;
         job_ff.norm_b <= norm_b_sat;
      end
   end

   always_comb begin
      job       = job_ff;
      job.start = start_ff;
   end

endmodule

`default_nettype wire

[rtl/core/cossim_finish.sv]
// ----------------------------------------------------------------------------
// cossim_finish
// Forms dot / sqrt(norm_a * norm_b) in Q1.15 with a shared sequential
// multiplier and a bit-by-bit square root search, and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module cossim_finish import cossim_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cossim_job_type  job,
   output logic                 busy,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output cossim_rsp_type       rsp_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_ADD  = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_PACK = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]          state_ff;
   logic [2:0]          state_in;

   // operands and intermediate values
   logic [NORM_W-1:0]   norm_a_ff;
   logic [NORM_W-1:0]   norm_b_ff;
   logic [MAG_W-1:0]    mag_ff;
   logic                neg_ff;
   logic                degen_ff;
   logic                mul_sel_ff;
   logic [STEP_W-1:0]   cnt_ff;
   logic [PP_W-1:0]     pp_ff;
   logic [1:0]          sh_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [P_W-1:0]      p_ff;
   logic [REM_W-1:0]    r_ff;
   logic [REM_W-1:0]    u_ff;
   logic [REM_W-1:0]    v_ff;
   logic [REM_W-1:0]    t_ff;
   logic [Q_W-1:0]      q_ff;
   cossim_rsp_type      rsp_ff;

   logic [MAG_W-1:0]    job_mag;
   logic [MAG_W-1:0]    mul_x;
   logic [MAG_W-1:0]    mul_y;
   logic [PART_W-1:0]   part_x;
   logic [PART_W-1:0]   part_y;
   logic [PP_W-1:0]     pp_in;
   logic [ACC_W-1:0]    pp_shift;
   logic [ACC_W-1:0]    acc_sum;
   logic [REM_W:0]      diff;
   logic                fit;
   logic                mul_done;
   logic                search_done;
   logic [Q_W-1:0]      q_neg;
   logic signed [OUT_W-1:0] sim_val;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

   // magnitude of the dot product
   assign job_mag = job.dot[DOT_W-1] ? (~MAG_W'(job.dot) + MAG_W'(1)) : MAG_W'(job.dot);

   // partial product selection: low or high half of each operand
   assign mul_x  = mul_sel_ff ? mag_ff : MAG_W'(norm_a_ff);
   assign mul_y  = mul_sel_ff ? mag_ff : MAG_W'(norm_b_ff);
   assign part_x = cnt_ff[0] ? PART_W'(mul_x >> PART_W) : mul_x[PART_W-1:0];
   assign part_y = cnt_ff[1] ? PART_W'(mul_y >> PART_W) : mul_y[PART_W-1:0];
   assign pp_in  = part_x * part_y;

   // align the registered partial product
   always_comb begin
      case (sh_ff)
         2'd0:    pp_shift = ACC_W'(pp_ff);
         2'd1:    pp_shift = ACC_W'(pp_ff) << PART_W;
         2'd2:    pp_shift = ACC_W'(pp_ff) << (2 * PART_W);
         default: pp_shift = '0;
      endcase
   end

   assign acc_sum  = acc_ff + pp_shift;
   assign mul_done = (cnt_ff == STEP_W'(MUL_STEPS));

   // root search trial: remainder minus next increment
   assign diff        = {1'b0, r_ff} - {1'b0, t_ff};
   assign fit         = !diff[REM_W];
   assign search_done = (fit && cnt_ff == STEP_W'(TOP_BIT)) || (cnt_ff == '0);

   // sign and saturation of the quotient
   assign q_neg   = ~q_ff + Q_W'(1);
   assign sim_val = neg_ff ? OUT_W'(q_neg)
                           : (q_ff[TOP_BIT] ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(q_ff));

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job.start) begin
               state_in = (job.norm_a == '0 || job.norm_b == '0) ? ST_PACK : ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done && mul_sel_ff) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: state_in = ST_CMP;
         ST_CMP: state_in = search_done ? ST_PACK : ST_ADD;
         ST_PACK: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            norm_a_ff  <= job.norm_a;
            norm_b_ff  <= job.norm_b;
            mag_ff     <= job_mag;
            neg_ff     <= job.dot[DOT_W-1];
            degen_ff   <= (job.norm_a == '0 || job.norm_b == '0);
            mul_sel_ff <= 1'b0;
            cnt_ff     <= '0;
            acc_ff     <= '0;
            q_ff       <= '0;
         end
         ST_MUL: begin
            if (!mul_done) begin
               pp_ff  <= pp_in;
               sh_ff  <= 2'(cnt_ff[0]) + 2'(cnt_ff[1]);
               cnt_ff <= cnt_ff + STEP_W'(1);
               if (cnt_ff != '0) begin
                  acc_ff <= acc_sum;
               end
            end else begin
               acc_ff <= '0;
               if (!mul_sel_ff) begin
                  // norm product done, square of the dot next
                  p_ff       <= acc_sum[P_W-1:0];
                  mul_sel_ff <= 1'b1;
                  cnt_ff     <= '0;
               end else begin
                  // start the root search at the top quotient bit
                  r_ff   <= REM_W'(acc_sum) << FRAC_SHIFT;
                  u_ff   <= '0;
                  v_ff   <= REM_W'(p_ff) << FRAC_SHIFT;
                  cnt_ff <= STEP_W'(TOP_BIT);
               end
            end
         end
         ST_ADD: begin
            t_ff <= u_ff + v_ff;
         end
         ST_CMP: begin
            if (fit) begin
               r_ff <= diff[REM_W-1:0];
               q_ff <= q_ff | (Q_W'(1) << cnt_ff);
               u_ff <= (u_ff >> 1) + v_ff;
            end else begin
               u_ff <= u_ff >> 1;
            end
            v_ff   <= v_ff >> 2;
            cnt_ff <= cnt_ff - STEP_W'(1);
         end
         ST_PACK: begin
            rsp_ff.similarity <= degen_ff ? '0 : sim_val;
            rsp_ff.degenerate <= degen_ff;
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/cossim_checker.sv]
// ----------------------------------------------------------------------------
// cossim_checker
// Port-level checks of the cosine similarity core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cosine_similarity_core_macros.svh"

module cossim_checker import cossim_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  wire cossim_req_type  req_data,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire cossim_rsp_type  rsp_data
);

   // a stalled result word stays offered
   `CSC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")

   // a stalled result word keeps its value
   `CSC_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp changed")

   // a degenerate result carries zero similarity
   `CSC_ASSERT(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate |-> rsp_data.similarity == '0, "degenerate nonzero")

   // after reset no result is pending and the input side is open
   `CSC_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid && req_ready, "not quiet after reset")

   // input word is not checked beyond its handshake here
   logic unused_req;
   assign unused_req = req_valid ^ (^req_data);

endmodule

bind cosine_similarity_core cossim_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[tb/cossim_result_check.sv]
// ----------------------------------------------------------------------------
// cossim_result_check
// Watches both channels of the cosine similarity core. It keeps its own
// dot and norm sums, predicts the result word for every closing pair and
// compares each result word taken from the core with the oldest prediction.
// ----------------------------------------------------------------------------

module cossim_result_check import cossim_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_ready,
   input  wire cossim_req_type req_data,
   input  wire logic           rsp_valid,
   input  wire logic           rsp_ready,
   input  wire cossim_rsp_type rsp_data,
   output int                  fail_count,
   output int                  pending
);

   localparam longint DOT_HI    = (longint'(1) <<< (DOT_W - 1)) - 1;
   localparam longint DOT_LO    = -(longint'(1) <<< (DOT_W - 1));
   localparam longint NORM_HI   = (longint'(1) <<< NORM_W) - 1;
   localparam int     SHOWN_MAX = 10;
   localparam logic [16:0] Q_FULL = 17'd32768;

   // running sums of the vectors still open
   logic signed [DOT_W-1:0] dot_sum    = '0;
   logic [NORM_W-1:0]       norm_a_sum = '0;
   logic [NORM_W-1:0]       norm_b_sum = '0;

   cossim_rsp_type expected_sim_q[$];
   int             mismatches = 0;

   // q*q*norm_a*norm_b stays within dot*dot*2^30
   function automatic bit q_fits(input logic [16:0] q, input logic [127:0] norm_prod,
                                 input logic [127:0] dot_sq);
      logic [127:0] q_sq;
      q_sq = 128'(q) * 128'(q);
      return (q_sq * norm_prod) <= dot_sq;
   endfunction

   // largest q up to 32768 with q <= 32768*|dot|/sqrt(na*nb), then signed and saturated
   function automatic cossim_rsp_type cosine_q15(input logic signed [DOT_W-1:0] dot,
                                                 input logic [NORM_W-1:0] norm_a,
                                                 input logic [NORM_W-1:0] norm_b);
      logic [127:0]   norm_prod;
      logic [127:0]   dot_mag;
      logic [127:0]   dot_sq;
      logic [16:0]    q;
      cossim_rsp_type word;
      word = '0;
      if (norm_a == '0 || norm_b == '0) begin
         word.degenerate = 1'b1;
         return word;
      end
      dot_mag   = 128'(dot < 0 ? -longint'(dot) : longint'(dot));
      norm_prod = 128'(norm_a) * 128'(norm_b);
      dot_sq    = (dot_mag * dot_mag) << FRAC_SHIFT;
      if (q_fits(Q_FULL, norm_prod, dot_sq)) begin
         q = Q_FULL;
      end else begin
         q = '0;
         for (int k = 14; k >= 0; k--) begin
            if (q_fits(q | (17'd1 << k), norm_prod, dot_sq))
               q = q | (17'd1 << k);
         end
      end
      if (dot < 0)
         word.similarity = OUT_W'(-q);
      else
         word.similarity = (q > 17'd32767) ? 16'sh7fff : OUT_W'(q);
      return word;
   endfunction

   always @(posedge clock) begin
      cossim_rsp_type           want;
      longint                   dot_next;
      longint                   na_next;
      longint                   nb_next;
      logic signed [ELEM_W-1:0] ea;
      logic signed [ELEM_W-1:0] eb;
      if (reset) begin
         dot_sum    = '0;
         norm_a_sum = '0;
         norm_b_sum = '0;
         expected_sim_q.delete();
      end else begin
         // result word against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_sim_q.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_MAX)
                  $display("unexpected result word: similarity %0d degenerate %0b",
                           $signed(rsp_data.similarity), rsp_data.degenerate);
            end else begin
               want = expected_sim_q.pop_front();
               if (rsp_data.similarity !== want.similarity ||
                   rsp_data.degenerate !== want.degenerate) begin
                  mismatches++;
                  if (mismatches <= SHOWN_MAX)
                     $display("result mismatch: similarity %0d (expected %0d), degenerate %0b (expected %0b)",
                              $signed(rsp_data.similarity), $signed(want.similarity),
                              rsp_data.degenerate, want.degenerate);
               end
            end
         end

         // accumulate the pair with saturation, close the vectors on the last pair
         if (req_valid && req_ready) begin
            ea       = req_data.elem_a;
            eb       = req_data.elem_b;
            dot_next = longint'(dot_sum) + longint'(ea) * longint'(eb);
            na_next  = longint'(norm_a_sum) + longint'(ea) * longint'(ea);
            nb_next  = longint'(norm_b_sum) + longint'(eb) * longint'(eb);
            dot_sum    = (dot_next > DOT_HI) ? DOT_W'(DOT_HI) :
                         (dot_next < DOT_LO) ? DOT_W'(DOT_LO) : DOT_W'(dot_next);
            norm_a_sum = (na_next > NORM_HI) ? NORM_W'(NORM_HI) : NORM_W'(na_next);
            norm_b_sum = (nb_next > NORM_HI) ? NORM_W'(NORM_HI) : NORM_W'(nb_next);
            if (req_data.last_pair) begin
               want           = cosine_q15(dot_sum, norm_a_sum, norm_b_sum);
               expected_sim_q = {expected_sim_q, want};
               dot_sum    = '0;
               norm_a_sum = '0;
               norm_b_sum = '0;
            end
         end
      end
      fail_count <= mismatches;
      pending    <= expected_sim_q.size();
   end

endmodule

[tb/cosine_similarity_core_tb.sv]
// ----------------------------------------------------------------------------
// cosine_similarity_core_tb
// Drives element pairs into the cosine similarity core: a few hand-picked
// vectors, then random vectors under several sender and receiver stall
// mixes. The result checker beside the core predicts and compares; this
// module gives the verdict.
// ----------------------------------------------------------------------------

module cosine_similarity_core_tb;
   import cossim_pkg::*;

   // run limit for the watchdog, set with ample margin
   localparam int RUN_LIMIT     = 600000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 100;
   localparam int PHASE_PAIRS   = 230;
   localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
   localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;

   typedef enum int { STYLE_FULL, STYLE_CORNER, STYLE_TINY } elem_style_type;
   typedef enum int {
      PAIR_FREE, PAIR_SAME, PAIR_NEGATED, PAIR_NEAR, PAIR_A_ZERO, PAIR_B_ZERO
   } pairing_type;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   cossim_req_type req_data  = '0;
   logic           req_ready;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   cossim_rsp_type rsp_data;

   int fail_count;
   int pending;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int pairs_sent     = 0;
   int cycle_count    = 0;
   int hold_left      = 0;
   bit hold_token     = 1'b0;
   bit hold_seen      = 1'b0;

   always #5 clock = ~clock;

   cosine_similarity_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   cossim_result_check result_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("** cosine_similarity_core: FAILED **");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off each time the token flips
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic signed [ELEM_W-1:0] pick_elem(input elem_style_type style);
      case (style)
         STYLE_CORNER: begin
            case ($urandom_range(4))
               0: return ELEM_MIN;
               1: return ELEM_MAX;
               2: return -16'sd1;
               3: return 16'sd1;
               default: return '0;
            endcase
         end
         STYLE_TINY: return ELEM_W'($urandom_range(8)) - 16'sd4;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   // offer one word after a random gap and hold it until taken
   task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                            input logic signed [ELEM_W-1:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.elem_a    <= a;
      req_data.elem_b    <= b;
      req_data.last_pair <= last;
      do @(posedge clock); while (!req_ready);
      pairs_sent++;
   endtask

   // sender pauses until every predicted word has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // one random pair of vectors, mostly short, now and then longer
   task automatic send_vector();
      int                       len;
      int                       pick;
      elem_style_type           style;
      pairing_type              how;
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
      len  = ($urandom_range(9) == 0) ? $urandom_range(64, 24) : $urandom_range(12, 1);
      pick = $urandom_range(9);
      style = (pick < 6) ? STYLE_FULL : (pick < 8) ? STYLE_CORNER : STYLE_TINY;
      case ($urandom_range(9))
         4: how = PAIR_SAME;
         5: how = PAIR_NEGATED;
         6, 7: how = PAIR_NEAR;
         8: how = PAIR_A_ZERO;
         9: how = PAIR_B_ZERO;
         default: how = PAIR_FREE;
      endcase
      for (int i = 0; i < len; i++) begin
         a = pick_elem(style);
         b = pick_elem(style);
         case (how)
            PAIR_SAME: b = a;
            PAIR_NEGATED: b = -a;
            PAIR_NEAR: b = a ^ ELEM_W'($urandom_range(15));
            PAIR_A_ZERO: a = '0;
            PAIR_B_ZERO: b = '0;
            default: ;
         endcase
         send_pair(a, b, i == len - 1);
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
      int target;
      target = pairs_sent + PHASE_PAIRS;
      send_idle_pct = send_pct;
      recv_stall_pct <= recv_pct;
      if (with_hold)
         hold_token <= ~hold_token;
      while (pairs_sent < target)
         send_vector();
      wait_drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-pair vectors: full match saturates, full opposition gives -32768
      send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
      send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
      // zero norms on both, on a only, on b only
      send_pair('0, '0, 1'b1);
      send_pair('0, 16'sd5, 1'b0);
      send_pair('0, -16'sd7, 1'b1);
      send_pair(16'sd3, '0, 1'b0);
      send_pair(-16'sd4, '0, 1'b1);
      // orthogonal vectors
      send_pair(16'sd1, '0, 1'b0);
      send_pair('0, 16'sd1, 1'b1);
      // most negative elements throughout
      send_pair(ELEM_MIN, ELEM_MIN, 1'b0);
      send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
      // mixed signs and magnitudes
      send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
      send_pair(-16'sd1, 16'sd1, 1'b0);
      send_pair(16'sd12345, -16'sd23456, 1'b0);
      send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
      wait_drain();

      // random vectors under each stall mix, the first with a long receiver hold-off
      run_phase(0, 0, 1'b1);
      run_phase(86, 0, 1'b0);
      run_phase(0, 86, 1'b0);
      run_phase(37, 37, 1'b0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** cosine_similarity_core: PASSED **");
      else
         $display("** cosine_similarity_core: FAILED **");
      $finish;
   end

endmodule
